// ----- src/sprite_xor_draw_engine_assert.svh -----
`ifndef SPRITE_XOR_DRAW_ENGINE_ASSERT_SVH
`define SPRITE_XOR_DRAW_ENGINE_ASSERT_SVH

// implication within the same cycle
`define SXD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sxd assertion failed");

// implication into the next cycle
`define SXD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sxd assertion failed");

`endif

// ----- src/sxd_pkg.sv -----
`default_nettype none

package sxd_pkg;

    localparam int DEF_SCREEN_WIDTH  = 64;
    localparam int DEF_SCREEN_HEIGHT = 32;
    localparam int DEF_RAM_DEPTH     = 4096;
    localparam int MAX_ROWS          = 16;
    localparam int PIX_PER_BYTE      = 8;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DRAW  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW_RD,
        ST_ROW_WAIT,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_FB_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
        logic [11:0] sprite_addr;
        logic [7:0]  sprite_x;
        logic [7:0]  sprite_y;
        logic [3:0]  row_count;
        logic [7:0]  screen_index;
    } t_in_item;

    typedef struct packed {
        logic       collision;
        logic [7:0] screen_data;
    } t_out_item;

    // reduce v modulo m (for v < 32*m) by conditional subtraction of m*16 .. m*1
    function automatic logic [11:0] mod_wrap(input logic [11:0] v, input int unsigned m);
        logic [16:0] acc;
        logic [16:0] sub;
        acc = 17'(v);
        for (int k = 4; k >= 0; k--) begin
            sub = 17'(m) << k;
            if (acc >= sub) begin
                acc = acc - sub;
            end
        end
        return acc[11:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/sxd_ram.sv -----
`default_nettype none

module sxd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/sprite_xor_draw_engine.sv -----
// From accept to result strobe: a memory write goes straight to the result state, a screen
// read waits on the framebuffer, a draw reads each sprite row and XORs in each set bit.
// One item at a time: busy stays high until the result cycle has ended.
// Each set sprite pixel is one framebuffer read then one write through a single port pair.
// Reset (synchronous): clears both memories, busy high meanwhile.
// Results are shown for one cycle on o_strobe; the receiver cannot stall.
`default_nettype none
`include "sprite_xor_draw_engine_assert.svh"

module sprite_xor_draw_engine #(
    parameter int SCREEN_WIDTH  = sxd_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = sxd_pkg::DEF_SCREEN_HEIGHT,
    parameter int RAM_DEPTH     = sxd_pkg::DEF_RAM_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire sxd_pkg::t_in_item i_item,
    output logic                   busy,
    output logic                   o_strobe,
    output sxd_pkg::t_out_item     o_result
);

    localparam int PIXELS    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int FB_BYTES  = (PIXELS + sxd_pkg::PIX_PER_BYTE - 1) / sxd_pkg::PIX_PER_BYTE;
    localparam int CLR_COUNT = (RAM_DEPTH > FB_BYTES) ? RAM_DEPTH : FB_BYTES;
    localparam int AW        = $clog2(RAM_DEPTH);
    localparam int FBW       = $clog2(FB_BYTES);
    localparam int XW        = $clog2(SCREEN_WIDTH);
    localparam int YW        = $clog2(SCREEN_HEIGHT);
    localparam int PW        = $clog2(PIXELS);
    localparam int CW        = $clog2(CLR_COUNT);
    localparam int RW        = $clog2(sxd_pkg::MAX_ROWS) + 1;

    sxd_pkg::t_state r_state, n_state;

    logic [CW-1:0]   r_clr, n_clr;
    logic [AW-1:0]   r_addr, n_addr;
    logic [XW-1:0]   r_x0, n_x0;
    logic [YW-1:0]   r_y, n_y;
    logic [RW-1:0]   r_rows, n_rows;
    logic [7:0]      r_bits, n_bits;
    logic [FBW-1:0]  r_fb_addr, n_fb_addr;
    logic [7:0]      r_mask, n_mask;
    logic            r_oob, n_oob;
    logic [1:0]      r_kind, n_kind;
    logic            r_collision, n_collision;
    logic [7:0]      r_screen, n_screen;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_rdata;
    logic            fb_we;
    logic [FBW-1:0]  fb_waddr;
    logic [7:0]      fb_wdata;
    logic [FBW-1:0]  fb_raddr;
    logic [7:0]      fb_rdata;

    logic            accept;
    logic [2:0]      col;
    logic [XW:0]     xs;
    logic [PW-1:0]   pix;
    logic [FBW-1:0]  pix_addr;
    logic [7:0]      pix_mask;
    logic [7:0]      col_bit;
    logic            idx_ok;
    logic            kind_draw;
    logic            kind_read;

    assign accept    = start && (r_state == sxd_pkg::ST_IDLE);
    assign idx_ok    = (11'(i_item.screen_index) < 11'(FB_BYTES));
    assign kind_draw = (r_kind == sxd_pkg::KIND_DRAW);
    assign kind_read = (r_kind == sxd_pkg::KIND_READ);

    sxd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_sprite_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    sxd_ram #(
        .WIDTH (8),
        .DEPTH (FB_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fb_we),
        .i_waddr (fb_waddr),
        .i_wdata (fb_wdata),
        .i_raddr (fb_raddr),
        .o_rdata (fb_rdata)
    );

    always_comb begin
        col = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (r_bits[i]) begin
                col = 3'(7 - i);
            end
        end
        col_bit  = 8'h80 >> col;
        xs       = (XW+1)'(r_x0) + (XW+1)'(col);
        if (xs >= (XW+1)'(SCREEN_WIDTH)) begin
            xs = xs - (XW+1)'(SCREEN_WIDTH);
        end
        pix      = PW'(r_y) * PW'(SCREEN_WIDTH) + PW'(xs[XW-1:0]);
        pix_addr = FBW'(pix >> 3);
        pix_mask = 8'h80 >> pix[2:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sxd_pkg::ST_CLEAR: begin
                if (r_clr == CW'(CLR_COUNT - 1)) begin
                    n_state = sxd_pkg::ST_IDLE;
                end
            end
            sxd_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_item.kind)
                        sxd_pkg::KIND_DRAW: n_state = sxd_pkg::ST_ROW_RD;
                        sxd_pkg::KIND_READ: n_state = sxd_pkg::ST_FB_WAIT;
                        default:            n_state = sxd_pkg::ST_DONE;
                    endcase
                end
            end
            sxd_pkg::ST_ROW_RD:   n_state = sxd_pkg::ST_ROW_WAIT;
            sxd_pkg::ST_ROW_WAIT: n_state = sxd_pkg::ST_PIX_RD;
            sxd_pkg::ST_PIX_RD: begin
                if (r_bits != 8'h00) begin
                    n_state = sxd_pkg::ST_PIX_WR;
                end else if (r_rows == RW'(1)) begin
                    n_state = sxd_pkg::ST_DONE;
                end else begin
                    n_state = sxd_pkg::ST_ROW_RD;
                end
            end
            sxd_pkg::ST_PIX_WR:  n_state = sxd_pkg::ST_PIX_RD;
            sxd_pkg::ST_FB_WAIT: n_state = sxd_pkg::ST_DONE;
            sxd_pkg::ST_DONE:    n_state = sxd_pkg::ST_IDLE;
            default:             n_state = sxd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        busy                 = (r_state != sxd_pkg::ST_IDLE);
        o_strobe             = (r_state == sxd_pkg::ST_DONE);
        o_result.collision   = r_collision;
        o_result.screen_data = r_screen;
        ram_we               = 1'b0;
        ram_waddr            = AW'(sxd_pkg::mod_wrap(i_item.mem_addr, RAM_DEPTH));
        ram_wdata            = i_item.mem_data;
        fb_we                = 1'b0;
        fb_waddr             = r_fb_addr;
        fb_wdata             = fb_rdata ^ r_mask;
        fb_raddr             = pix_addr;
        case (r_state)
            sxd_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr[AW-1:0];
                ram_wdata = 8'h00;
                fb_we     = 1'b1;
                fb_waddr  = r_clr[FBW-1:0];
                fb_wdata  = 8'h00;
            end
            sxd_pkg::ST_IDLE: begin
                ram_we   = accept && (i_item.kind == sxd_pkg::KIND_WRITE);
                fb_raddr = FBW'(i_item.screen_index);
            end
            sxd_pkg::ST_PIX_WR: begin
                fb_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_x0        = r_x0;
        n_y         = r_y;
        n_rows      = r_rows;
        n_bits      = r_bits;
        n_fb_addr   = r_fb_addr;
        n_mask      = r_mask;
        n_oob       = r_oob;
        n_kind      = r_kind;
        n_collision = r_collision;
        n_screen    = r_screen;
        case (r_state)
            sxd_pkg::ST_CLEAR: begin
                n_clr = r_clr + CW'(1);
            end
            sxd_pkg::ST_IDLE: begin
                if (accept) begin
                    n_kind      = i_item.kind;
                    n_collision = 1'b0;
                    n_screen    = 8'h00;
                    n_oob       = !idx_ok;
                    n_addr      = AW'(sxd_pkg::mod_wrap(i_item.sprite_addr, RAM_DEPTH));
                    n_x0        = XW'(sxd_pkg::mod_wrap(12'(i_item.sprite_x), SCREEN_WIDTH));
                    n_y         = YW'(sxd_pkg::mod_wrap(12'(i_item.sprite_y), SCREEN_HEIGHT));
                    n_rows      = (i_item.row_count == 4'd0) ? RW'(sxd_pkg::MAX_ROWS)
                                                             : RW'(i_item.row_count);
                end
            end
            sxd_pkg::ST_ROW_WAIT: begin
                n_bits = ram_rdata;
            end
            sxd_pkg::ST_PIX_RD: begin
                if (r_bits != 8'h00) begin
                    n_bits    = r_bits & ~col_bit;
                    n_fb_addr = pix_addr;
                    n_mask    = pix_mask;
                end else begin
                    n_rows = r_rows - RW'(1);
                    n_addr = (r_addr == AW'(RAM_DEPTH - 1)) ? '0 : r_addr + AW'(1);
                    n_y    = (r_y == YW'(SCREEN_HEIGHT - 1)) ? '0 : r_y + YW'(1);
                end
            end
            sxd_pkg::ST_PIX_WR: begin
                n_collision = r_collision | (|(fb_rdata & r_mask));
            end
            sxd_pkg::ST_FB_WAIT: begin
                n_screen = r_oob ? 8'h00 : fb_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sxd_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_addr      <= n_addr;
        r_x0        <= n_x0;
        r_y         <= n_y;
        r_rows      <= n_rows;
        r_bits      <= n_bits;
        r_fb_addr   <= n_fb_addr;
        r_mask      <= n_mask;
        r_oob       <= n_oob;
        r_kind      <= n_kind;
        r_collision <= n_collision;
        r_screen    <= n_screen;
    end

    `SXD_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy)
    `SXD_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `SXD_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    `SXD_ASSERT_IMP(a_hit_on_draw, i_clk, i_rst_n, o_strobe && !kind_draw, !o_result.collision)
    `SXD_ASSERT_IMP(a_data_on_read, i_clk, i_rst_n, o_strobe && !kind_read, o_result.screen_data == 8'h00)

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int SW       = sxd_pkg::DEF_SCREEN_WIDTH;
    localparam int SH       = sxd_pkg::DEF_SCREEN_HEIGHT;
    localparam int RD       = sxd_pkg::DEF_RAM_DEPTH;
    localparam int FB_BYTES = (SW * SH + 7) / 8;
    localparam int TAIL     = 320;
    localparam int IN_W     = $bits(sxd_pkg::t_in_item);

    typedef struct {
        sxd_pkg::t_in_item it;
        int                idle_pct;
        bit                drain;
    } t_pend_entry;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    sxd_pkg::t_in_item  item = '0;
    logic               busy;
    logic               strobe;
    sxd_pkg::t_out_item result;

    t_pend_entry        pend[$];
    sxd_pkg::t_out_item expected_results[int];
    int        n_acc = 0;
    int        n_chk = 0;
    int        n_err = 0;
    int        phase_idle = 0;
    bit        drain_next = 1'b0;

    logic [7:0] ram_model[RD];
    logic [7:0] fb_model[FB_BYTES];

    sprite_xor_draw_engine i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .i_item   (item),
        .busy     (busy),
        .o_strobe (strobe),
        .o_result (result)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        foreach (ram_model[a]) ram_model[a] = '0;
        foreach (fb_model[a]) fb_model[a] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic pixel_at(int p);
        if (p >= SW * SH) begin
            return 1'b0;
        end
        return fb_model[p >> 3][7 - (p & 7)];
    endfunction

    // Advance the screen and memory image by one item, return the result it gives.
    function automatic sxd_pkg::t_out_item apply_item(sxd_pkg::t_in_item it);
        sxd_pkg::t_out_item r;
        int        rows;
        int        x0;
        int        y0;
        int        row;
        int        col;
        int        p;
        logic [7:0] bits;
        r = '0;
        case (it.kind)
            sxd_pkg::KIND_WRITE: begin
                ram_model[int'(it.mem_addr) % RD] = it.mem_data;
            end
            sxd_pkg::KIND_DRAW: begin
                rows = (it.row_count == 0) ? sxd_pkg::MAX_ROWS : int'(it.row_count);
                x0 = int'(it.sprite_x) % SW;
                y0 = int'(it.sprite_y) % SH;
                for (row = 0; row < rows; row++) begin
                    bits = ram_model[(int'(it.sprite_addr) + row) % RD];
                    for (col = 0; col < 8; col++) begin
                        if (bits[7 - col]) begin
                            p = ((y0 + row) % SH) * SW + (x0 + col) % SW;
                            if (pixel_at(p)) begin
                                r.collision = 1'b1;
                            end
                            if (p < SW * SH) begin
                                fb_model[p >> 3][7 - (p & 7)] = ~fb_model[p >> 3][7 - (p & 7)];
                            end
                        end
                    end
                end
            end
            sxd_pkg::KIND_READ: begin
                for (col = 0; col < 8; col++) begin
                    r.screen_data = {r.screen_data[6:0], pixel_at(int'(it.screen_index) * 8 + col)};
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Bias addresses towards a small window so draws mostly pick up written bytes.
    function automatic logic [11:0] pick_addr();
        int w;
        w = $urandom_range(99);
        if (w < 80) begin
            return 12'($urandom_range(47));
        end else if (w < 90) begin
            return 12'($urandom_range(4095, 4080));
        end
        return 12'($urandom);
    endfunction

    function automatic sxd_pkg::t_in_item rand_item();
        sxd_pkg::t_in_item it;
        int       w;
        it = sxd_pkg::t_in_item'(IN_W'({$urandom, $urandom}));
        w = $urandom_range(99);
        if (w < 35) begin
            it.kind = sxd_pkg::KIND_WRITE;
            it.mem_addr = pick_addr();
        end else if (w < 65) begin
            it.kind = sxd_pkg::KIND_DRAW;
            it.sprite_addr = pick_addr();
        end else if (w < 95) begin
            it.kind = sxd_pkg::KIND_READ;
        end else begin
            it.kind = sxd_pkg::KIND_NONE;
        end
        return it;
    endfunction

    task automatic push_item(sxd_pkg::t_in_item it);
        t_pend_entry e;
        e.it = it;
        e.idle_pct = phase_idle;
        e.drain = drain_next;
        drain_next = 1'b0;
        pend.push_back(e);
    endtask

    task automatic push_write(logic [11:0] a, logic [7:0] d);
        sxd_pkg::t_in_item it;
        it = rand_item();
        it.kind = sxd_pkg::KIND_WRITE;
        it.mem_addr = a;
        it.mem_data = d;
        push_item(it);
    endtask

    task automatic push_draw(logic [11:0] a, logic [7:0] x, logic [7:0] y, logic [3:0] n);
        sxd_pkg::t_in_item it;
        it = rand_item();
        it.kind = sxd_pkg::KIND_DRAW;
        it.sprite_addr = a;
        it.sprite_x = x;
        it.sprite_y = y;
        it.row_count = n;
        push_item(it);
    endtask

    task automatic push_read(logic [7:0] k);
        sxd_pkg::t_in_item it;
        it = rand_item();
        it.kind = sxd_pkg::KIND_READ;
        it.screen_index = k;
        push_item(it);
    endtask

    always @(posedge clk) begin : drive
        t_pend_entry slot;
        int        owed;
        if (!rst_n) begin
            start <= 1'b0;
            item  <= '0;
        end else begin
            owed = n_acc - n_chk;
            if (start && !busy) begin
                expected_results[n_acc] = apply_item(item);
                n_acc <= n_acc + 1;
                owed++;
            end
            if (!start || !busy) begin
                if (pend.size() != 0 && !(pend[0].drain && owed != 0) &&
                    $urandom_range(99) >= pend[0].idle_pct) begin
                    slot = pend.pop_front();
                    start <= 1'b1;
                    item  <= slot.it;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : check
        sxd_pkg::t_out_item want;
        if (rst_n && strobe) begin
            if (n_chk < n_acc) begin
                want = expected_results[n_chk];
                if (result.collision !== want.collision) begin
                    $display("%0t: collision expected %0d got %0d",
                             $time, want.collision, result.collision);
                    n_err++;
                end
                if (result.screen_data !== want.screen_data) begin
                    $display("%0t: screen_data expected %02h got %02h",
                             $time, want.screen_data, result.screen_data);
                    n_err++;
                end
                expected_results.delete(n_chk);
                n_chk <= n_chk + 1;
            end else begin
                $display("%0t: unexpected result: expected none, got collision %0d data %02h",
                         $time, result.collision, result.screen_data);
                n_err++;
            end
        end
    end

    initial begin
        sxd_pkg::t_in_item it;
        int       ph;
        int       cnt;
        int       idles[4];
        int       sizes[4];
        idles = '{0, 76, 18, 0};
        sizes = '{400, 450, 450, 350};

        push_read(8'd0);
        push_read(8'd255);
        push_write(12'd0, 8'hFF);
        push_write(12'd4095, 8'h81);
        push_write(12'd1, 8'h3C);
        push_draw(12'd0, 8'd0, 8'd0, 4'd1);
        push_draw(12'd0, 8'd0, 8'd0, 4'd1);
        push_draw(12'd4095, 8'd60, 8'd31, 4'd2);
        push_read(8'd255);
        push_read(8'd248);
        push_read(8'd0);
        push_draw(12'd4090, 8'd255, 8'd255, 4'd0);
        push_draw(12'd4090, 8'd255, 8'd255, 4'd0);
        it = '1;
        push_item(it);
        push_write(12'd4095, 8'h00);
        push_draw(12'd4095, 8'd128, 8'd64, 4'd15);
        push_read(8'd7);
        push_read(8'd8);
        push_write(12'd2, 8'hFF);
        push_draw(12'd2, 8'd7, 8'd0, 4'd1);
        push_read(8'd0);
        push_read(8'd1);

        for (ph = 0; ph < 4; ph++) begin
            phase_idle = idles[ph];
            drain_next = (ph != 0);
            for (cnt = 0; cnt < sizes[ph]; cnt++) begin
                if ($urandom_range(99) == 0) begin
                    drain_next = 1'b1;
                end
                push_item(rand_item());
            end
        end

        while (pend.size() != 0 || start || n_chk != n_acc) begin
            @(posedge clk);
        end
        repeat (TAIL) @(posedge clk);
        @(negedge clk);
        if (n_chk != n_acc) begin
            $display("%0t: %0d results still expected, got none", $time, n_acc - n_chk);
            n_err++;
        end
        if (n_err == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
